>>> hdl/rrwlt_pkg.sv
// Shared types and constants for the random walk local time histogram engine.
// Depends on nothing; the design files refer to it by scoped names, the testbench files import it.
`default_nettype none

package rrwlt_pkg;

    // Default sizes handed to the top level parameters.
    localparam int NUM_BINS_DEF    = 4096;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Fixed field widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int HIST_W     = 32;
    localparam int COUNT_W    = 24;
    localparam int DIV_W      = 16;
    localparam int BIN_OUT_W  = 12;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESET_THRESHOLD = 3'd0,
        REG_DRIFT_STEP      = 3'd1,
        REG_NOISE_SCALE     = 3'd2,
        REG_RESET_POSITION  = 3'd3,
        REG_WINDOW_HALF     = 3'd4,
        REG_STEPS_PER_RUN   = 3'd5,
        REG_COUNTS_PER_BIN  = 3'd6
    } cfg_reg_t;

    // Request type of an input item.
    typedef enum logic {
        OP_STEP = 1'b0,
        OP_READ = 1'b1
    } op_t;

    // Kind of a result item.
    typedef enum logic [1:0] {
        KIND_STEP    = 2'd0,
        KIND_RUN_END = 2'd1,
        KIND_READ    = 2'd2
    } kind_t;

    // Input request payload.
    typedef struct packed {
        op_t                req_type;
        logic [31:0]        reset_draw;
        logic signed [15:0] gauss_sample;
        logic [11:0]        read_bin;
    } in_item_t;

    // Result payload.
    typedef struct packed {
        kind_t              result_kind;
        logic signed [31:0] walk_position;
        logic [11:0]        bin_index;
        logic [31:0]        bin_value;
    } out_item_t;

    // Configuration register file.
    typedef struct packed {
        logic [31:0]        reset_threshold;
        logic signed [31:0] drift_step;
        logic [23:0]        noise_scale;
        logic signed [31:0] reset_position;
        logic [30:0]        window_half;
        logic [23:0]        steps_per_run;
        logic [15:0]        counts_per_bin;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        reset_threshold: 32'd257698,
        drift_step:      32'sd0,
        noise_scale:     24'd167772,
        reset_position:  32'sd16777216,
        window_half:     31'd83886,
        steps_per_run:   24'd100001,
        counts_per_bin:  16'd10
    };

    // Classified request as it travels through the queue.
    typedef struct packed {
        op_t                op;
        logic               take_reset;
        logic signed [15:0] gauss_sample;
        logic [11:0]        read_bin;
        logic               bin_valid;
    } q_item_t;

endpackage

`default_nettype wire

>>> hdl/rrwlt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on rrwlt_pkg for its default depth.
`default_nettype none

module rrwlt_ram #(
    parameter int WIDTH = rrwlt_pkg::HIST_W,
    parameter int DEPTH = rrwlt_pkg::NUM_BINS_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/rrwlt_fifo.sv
// Short request queue between the front and back parts of the engine.
// Depends on rrwlt_pkg for its default depth.
`default_nettype none

module rrwlt_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = rrwlt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer wrap and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

endmodule

`default_nettype wire

>>> hdl/rrwlt_front.sv
// Front part: accepts requests and classifies them for the back part.
// Depends on rrwlt_pkg for the request and queue item types.
`default_nettype none

module rrwlt_front #(
    parameter int NUM_BINS = rrwlt_pkg::NUM_BINS_DEF
) (
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rrwlt_pkg::in_item_t  s_data,
    input  logic [31:0]          reset_threshold,
    input  logic                 clearing,
    input  logic                 q_full,
    output logic                 q_push,
    output rrwlt_pkg::q_item_t   q_item
);

    // Requests wait while the histogram is cleared or the queue is full.
    assign s_ready = !clearing && !q_full;
    assign q_push  = s_valid && s_ready;

    // Decide the reset draw and the bin range check up front.
    always_comb begin
        q_item.op           = s_data.req_type;
        q_item.take_reset   = (s_data.reset_draw < reset_threshold);
        q_item.gauss_sample = s_data.gauss_sample;
        q_item.read_bin     = s_data.read_bin;
        q_item.bin_valid    = (32'(s_data.read_bin) < 32'(NUM_BINS));
    end

endmodule

`default_nettype wire

>>> hdl/rrwlt_back.sv
// Back part: walk arithmetic, window counting, bin division, histogram update and reads.
// Depends on rrwlt_pkg and rrwlt_ram.
`default_nettype none

module rrwlt_back #(
    parameter int NUM_BINS = rrwlt_pkg::NUM_BINS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rrwlt_pkg::cfg_t       cfg,
    input  logic                  q_empty,
    input  rrwlt_pkg::q_item_t    q_head,
    output logic                  q_pop,
    output logic                  clearing,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rrwlt_pkg::out_item_t  m_data
);

    localparam int BIN_W     = $clog2(NUM_BINS);
    localparam int CW        = rrwlt_pkg::COUNT_W;
    localparam int DW        = rrwlt_pkg::DIV_W;
    localparam int DCNT_W    = $clog2(CW);
    localparam logic [BIN_W-1:0]  LAST_BIN = BIN_W'(NUM_BINS - 1);
    localparam logic [CW-1:0]     MAX_QUO  = CW'(NUM_BINS - 1);
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(CW - 1);
    localparam logic signed [33:0] SUM_MAX = 34'sd2147483647;
    localparam logic signed [33:0] SUM_MIN = -34'sd2147483648;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MUL   = 9'b000000010,
        ST_SUM   = 9'b000000100,
        ST_WIN   = 9'b000001000,
        ST_DIV   = 9'b000010000,
        ST_BIN   = 9'b000100000,
        ST_UPD   = 9'b001000000,
        ST_RDATA = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t                    state_reg, state_next;
    rrwlt_pkg::q_item_t        item_reg, item_next;
    logic signed [40:0]        prod_reg, prod_next;
    logic signed [32:0]        base_reg, base_next;
    logic signed [31:0]        walk_reg, walk_next;
    logic signed [31:0]        position_reg, position_next;
    logic [CW-1:0]             wcount_reg, wcount_next;
    logic [CW-1:0]             sidx_reg, sidx_next;
    logic [CW-1:0]             quo_reg, quo_next;
    logic [DW-1:0]             rem_reg, rem_next;
    logic [DW-1:0]             div_reg, div_next;
    logic [DCNT_W-1:0]         dcnt_reg, dcnt_next;
    logic [BIN_W-1:0]          bin_reg, bin_next;
    rrwlt_pkg::out_item_t      res_reg, res_next;
    logic                      m_valid_reg, m_valid_next;
    rrwlt_pkg::out_item_t      m_data_reg, m_data_next;
    logic                      clr_active_reg, clr_active_next;
    logic [BIN_W-1:0]          clr_addr_reg, clr_addr_next;

    // Datapath intermediates.
    logic signed [40:0]        rounded;
    logic signed [28:0]        noise;
    logic signed [33:0]        sum;
    logic signed [31:0]        sum_sat;
    logic signed [32:0]        win_lo;
    logic signed [32:0]        win_hi;
    logic                      in_win;
    logic [CW-1:0]             wc_new;
    logic [CW-1:0]             sidx_inc;
    logic [CW-1:0]             run_limit;
    logic                      run_end;
    logic [DW:0]               trial;
    logic                      trial_ge;
    logic [BIN_W-1:0]          bin_sel;
    logic [31:0]               hist_inc;

    // Histogram memory ports.
    logic                      ram_we;
    logic [BIN_W-1:0]          ram_waddr;
    logic [31:0]               ram_wdata;
    logic                      ram_re;
    logic [BIN_W-1:0]          ram_raddr;
    logic [31:0]               ram_rdata;
    logic                      upd_we;

    rrwlt_ram #(
        .WIDTH(rrwlt_pkg::HIST_W),
        .DEPTH(NUM_BINS)
    ) u_hist (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Rounded noise term and saturated new position.
    always_comb begin
        rounded = prod_reg + 41'sd2048;
        noise   = rounded[40:12];
        sum     = 34'(base_reg) + 34'(noise);
        if (sum > SUM_MAX) begin
            sum_sat = 32'sh7FFFFFFF;
        end else if (sum < SUM_MIN) begin
            sum_sat = 32'sh80000000;
        end else begin
            sum_sat = sum[31:0];
        end
    end

    // Window test, counter updates and end of run detection.
    always_comb begin
        win_lo    = 33'(cfg.reset_position) - $signed({2'b00, cfg.window_half});
        win_hi    = 33'(cfg.reset_position) + $signed({2'b00, cfg.window_half});
        in_win    = (33'(walk_reg) > win_lo) && (33'(walk_reg) < win_hi);
        wc_new    = (in_win && (wcount_reg != '1)) ? wcount_reg + 1'b1 : wcount_reg;
        sidx_inc  = sidx_reg + 1'b1;
        run_limit = (cfg.steps_per_run == '0) ? CW'(1) : cfg.steps_per_run;
        run_end   = (sidx_inc >= run_limit) || (sidx_inc == '0);
    end

    // One restoring division step, bin saturation and count increment.
    always_comb begin
        trial    = {rem_reg, quo_reg[CW-1]};
        trial_ge = (trial >= {1'b0, div_reg});
        bin_sel  = (quo_reg > MAX_QUO) ? LAST_BIN : BIN_W'(quo_reg);
        hist_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + 32'd1;
    end

    // Sequencer for one request at a time.
    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        prod_next     = prod_reg;
        base_next     = base_reg;
        walk_next     = walk_reg;
        position_next = position_reg;
        wcount_next   = wcount_reg;
        sidx_next     = sidx_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        div_next      = div_reg;
        dcnt_next     = dcnt_reg;
        bin_next      = bin_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        q_pop         = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = bin_reg;
        upd_we        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (!clr_active_reg && !q_empty) begin
                    q_pop     = 1'b1;
                    item_next = q_head;
                    if (q_head.op == rrwlt_pkg::OP_READ) begin
                        ram_re     = q_head.bin_valid;
                        ram_raddr  = BIN_W'(q_head.read_bin);
                        state_next = ST_RDATA;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                prod_next  = $signed({1'b0, cfg.noise_scale}) * item_reg.gauss_sample;
                base_next  = 33'(position_reg) - 33'(cfg.drift_step);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                walk_next  = item_reg.take_reset ? cfg.reset_position : sum_sat;
                state_next = ST_WIN;
            end
            ST_WIN: begin
                if (run_end) begin
                    position_next = cfg.reset_position;
                    wcount_next   = '0;
                    sidx_next     = '0;
                    quo_next      = wc_new;
                    rem_next      = '0;
                    div_next      = (cfg.counts_per_bin == '0) ? DW'(1) : cfg.counts_per_bin;
                    dcnt_next     = '0;
                    state_next    = ST_DIV;
                end else begin
                    position_next          = walk_reg;
                    wcount_next            = wc_new;
                    sidx_next              = sidx_inc;
                    res_next.result_kind   = rrwlt_pkg::KIND_STEP;
                    res_next.walk_position = walk_reg;
                    res_next.bin_index     = '0;
                    res_next.bin_value     = '0;
                    state_next             = ST_OUT;
                end
            end
            ST_DIV: begin
                rem_next  = trial_ge ? DW'(trial - {1'b0, div_reg}) : trial[DW-1:0];
                quo_next  = {quo_reg[CW-2:0], trial_ge};
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DIV_LAST) begin
                    state_next = ST_BIN;
                end
            end
            ST_BIN: begin
                bin_next   = bin_sel;
                ram_re     = 1'b1;
                ram_raddr  = bin_sel;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                upd_we                 = 1'b1;
                res_next.result_kind   = rrwlt_pkg::KIND_RUN_END;
                res_next.walk_position = walk_reg;
                res_next.bin_index     = rrwlt_pkg::BIN_OUT_W'(bin_reg);
                res_next.bin_value     = hist_inc;
                state_next             = ST_OUT;
            end
            ST_RDATA: begin
                res_next.result_kind   = rrwlt_pkg::KIND_READ;
                res_next.walk_position = position_reg;
                res_next.bin_index     = item_reg.read_bin;
                res_next.bin_value     = item_reg.bin_valid ? ram_rdata : '0;
                state_next             = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Clearing pass over the histogram after reset.
    always_comb begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_BIN) begin
                clr_active_next = 1'b0;
            end
        end
    end

    // The write port is shared by the clearing pass and the bin update.
    assign ram_we    = clr_active_reg || upd_we;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : bin_reg;
    assign ram_wdata = clr_active_reg ? '0 : hist_inc;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            position_reg   <= rrwlt_pkg::CFG_RESET.reset_position;
            wcount_reg     <= '0;
            sidx_reg       <= '0;
            m_valid_reg    <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            position_reg   <= position_next;
            wcount_reg     <= wcount_next;
            sidx_reg       <= sidx_next;
            m_valid_reg    <= m_valid_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        prod_reg   <= prod_next;
        base_reg   <= base_next;
        walk_reg   <= walk_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        dcnt_reg   <= dcnt_next;
        bin_reg    <= bin_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign clearing = clr_active_reg;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // The queue is only popped when it holds a request.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("request popped from an empty queue");

    // No request is worked on while the histogram is being cleared.
    a_clear_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> (state_reg == ST_IDLE))
        else $error("sequencer left idle during the clearing pass");

    // The end of a run restarts the walker and both counters.
    a_run_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WIN && run_end) |=>
            (position_reg == $past(cfg.reset_position) && wcount_reg == '0 && sidx_reg == '0))
        else $error("walk did not restart after the end of a run");

    // Histogram writes stay inside the configured bin range.
    a_waddr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (ram_waddr <= LAST_BIN))
        else $error("histogram write beyond the last bin");

endmodule

`default_nettype wire

>>> hdl/reset_random_walk_local_time.sv
// Sequence: a step request passes the back states MUL, SUM, WIN and OUT; a step that ends
// a run goes from WIN through the bit-serial bin division (DIV), BIN and UPD; a read, RDATA.
// The back sequencer works on one request at a time and takes no new one before it is
// through with the last; a 2-entry queue buffers the front.
// Reset: synchronous, active low; the histogram is then cleared bin by bin, during which
// s_ready is low. Configuration writes are taken at any time.
`default_nettype none

module reset_random_walk_local_time #(
    parameter int NUM_BINS    = rrwlt_pkg::NUM_BINS_DEF,
    parameter int QUEUE_DEPTH = rrwlt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rrwlt_pkg::in_item_t                 s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rrwlt_pkg::out_item_t                m_data,
    input  logic                                cfg_wr_en,
    input  logic [rrwlt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rrwlt_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    localparam int Q_W = $bits(rrwlt_pkg::q_item_t);

    rrwlt_pkg::cfg_t     cfg_reg, cfg_next;
    rrwlt_pkg::q_item_t  q_item;
    rrwlt_pkg::q_item_t  q_head;
    logic [Q_W-1:0]      q_head_bits;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    logic                clearing;

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                rrwlt_pkg::REG_RESET_THRESHOLD: cfg_next.reset_threshold = cfg_wr_data;
                rrwlt_pkg::REG_DRIFT_STEP:      cfg_next.drift_step      = cfg_wr_data;
                rrwlt_pkg::REG_NOISE_SCALE:     cfg_next.noise_scale     = cfg_wr_data[23:0];
                rrwlt_pkg::REG_RESET_POSITION:  cfg_next.reset_position  = cfg_wr_data;
                rrwlt_pkg::REG_WINDOW_HALF:     cfg_next.window_half     = cfg_wr_data[30:0];
                rrwlt_pkg::REG_STEPS_PER_RUN:   cfg_next.steps_per_run   = cfg_wr_data[23:0];
                rrwlt_pkg::REG_COUNTS_PER_BIN:  cfg_next.counts_per_bin  = cfg_wr_data[15:0];
                default:                        cfg_next                 = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= rrwlt_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front part: acceptance and classification.
    rrwlt_front #(
        .NUM_BINS(NUM_BINS)
    ) u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .reset_threshold(cfg_reg.reset_threshold),
        .clearing       (clearing),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (q_item)
    );

    // Request queue between the two parts.
    rrwlt_fifo #(
        .WIDTH(Q_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_item),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head_bits),
        .empty    (q_empty)
    );

    assign q_head = rrwlt_pkg::q_item_t'(q_head_bits);

    // Back part: walk update, histogram and result register.
    rrwlt_back #(
        .NUM_BINS(NUM_BINS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .clearing(clearing),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

>>> sim/rrwlt_checker.sv
// Result checker for the random walk local time engine: it follows the request, result
// and register write ports, predicts every result and compares it field by field.
// Depends on rrwlt_pkg for the payload types, register names and reset values.
`timescale 1ns / 100ps

module rrwlt_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  rrwlt_pkg::in_item_t              s_data,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  rrwlt_pkg::out_item_t             m_data,
    input  logic                             cfg_wr_en,
    input  logic [rrwlt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rrwlt_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output int                               fail_count,
    output int                               outstanding,
    output int                               results_checked,
    output int                               runs_closed
);
    import rrwlt_pkg::*;

    localparam int     LAST_BIN = NUM_BINS_DEF - 1;
    localparam longint POS_MAX  = 64'sd2147483647;
    localparam longint POS_MIN  = -64'sd2147483648;

    // Shadow copy of the register file and of the walker state.
    cfg_t        knobs;
    longint      walker_pos;
    logic [23:0] win_count;
    logic [23:0] step_idx;
    logic [31:0] bin_count [0:NUM_BINS_DEF-1];

    out_item_t   replies_due [$];
    int          mismatches;
    int          checked;
    int          closed;

    // Advances the walk by one request and returns the result it must produce.
    function automatic out_item_t advance_walk(in_item_t req);
        out_item_t   rep;
        longint      centre;
        longint      half;
        longint      noise;
        longint      nxt;
        logic [23:0] limit;
        logic [15:0] divisor;
        logic [23:0] bin_sel;
        rep = '0;
        centre = longint'($signed(knobs.reset_position));
        half = longint'(knobs.window_half);
        if (req.req_type == OP_READ) begin
            // Every 12-bit address lies inside the 4096-bin histogram.
            rep.result_kind = KIND_READ;
            rep.bin_index = req.read_bin;
            rep.bin_value = bin_count[req.read_bin];
            rep.walk_position = walker_pos[31:0];
        end else begin
            if (req.reset_draw < knobs.reset_threshold) begin
                nxt = centre;
            end else begin
                // Q0.24 times Q4.12, rounded half up back to Q8.24.
                noise = (longint'(knobs.noise_scale) * longint'($signed(req.gauss_sample))
                         + 2048) >>> 12;
                nxt = walker_pos - longint'($signed(knobs.drift_step)) + noise;
                if (nxt > POS_MAX) nxt = POS_MAX;
                if (nxt < POS_MIN) nxt = POS_MIN;
            end
            // The window test is strict on both sides and never wraps.
            if (nxt > centre - half && nxt < centre + half && win_count != 24'hFFFFFF) begin
                win_count = win_count + 24'd1;
            end
            step_idx = step_idx + 24'd1;
            limit = (knobs.steps_per_run == '0) ? 24'd1 : knobs.steps_per_run;
            if (step_idx >= limit || step_idx == '0) begin
                divisor = (knobs.counts_per_bin == '0) ? 16'd1 : knobs.counts_per_bin;
                bin_sel = win_count / divisor;
                if (bin_sel > LAST_BIN) bin_sel = 24'(LAST_BIN);
                if (bin_count[bin_sel] != 32'hFFFF_FFFF) begin
                    bin_count[bin_sel] = bin_count[bin_sel] + 32'd1;
                end
                rep.result_kind = KIND_RUN_END;
                rep.bin_index = bin_sel[11:0];
                rep.bin_value = bin_count[bin_sel];
                walker_pos = centre;
                win_count = '0;
                step_idx = '0;
                closed++;
            end else begin
                rep.result_kind = KIND_STEP;
                walker_pos = nxt;
            end
            rep.walk_position = nxt[31:0];
        end
        return rep;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        int        b;
        if (!aresetn) begin
            knobs = CFG_RESET;
            walker_pos = longint'($signed(CFG_RESET.reset_position));
            win_count = '0;
            step_idx = '0;
            for (b = 0; b < NUM_BINS_DEF; b++) bin_count[b] = '0;
            replies_due.delete();
            mismatches = 0;
            checked = 0;
            closed = 0;
        end else begin
            // Compare each accepted result with the oldest prediction.
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    $error("result with no request outstanding: kind %0d position %0d",
                           m_data.result_kind, $signed(m_data.walk_position));
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    checked++;
                    if (m_data.result_kind != want.result_kind) begin
                        $error("result_kind: expected %0d, got %0d",
                               want.result_kind, m_data.result_kind);
                        mismatches++;
                    end
                    if (m_data.walk_position != want.walk_position) begin
                        $error("walk_position: expected %0d, got %0d",
                               $signed(want.walk_position), $signed(m_data.walk_position));
                        mismatches++;
                    end
                    if (m_data.bin_index != want.bin_index) begin
                        $error("bin_index: expected %0d, got %0d",
                               want.bin_index, m_data.bin_index);
                        mismatches++;
                    end
                    if (m_data.bin_value != want.bin_value) begin
                        $error("bin_value: expected %0d, got %0d",
                               want.bin_value, m_data.bin_value);
                        mismatches++;
                    end
                end
            end

            // Register writes take effect at once.
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    REG_RESET_THRESHOLD: knobs.reset_threshold = cfg_wr_data;
                    REG_DRIFT_STEP:      knobs.drift_step = cfg_wr_data;
                    REG_NOISE_SCALE:     knobs.noise_scale = cfg_wr_data[23:0];
                    REG_RESET_POSITION:  knobs.reset_position = cfg_wr_data;
                    REG_WINDOW_HALF:     knobs.window_half = cfg_wr_data[30:0];
                    REG_STEPS_PER_RUN:   knobs.steps_per_run = cfg_wr_data[23:0];
                    REG_COUNTS_PER_BIN:  knobs.counts_per_bin = cfg_wr_data[15:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready) replies_due.push_back(advance_walk(s_data));
        end
        fail_count <= mismatches;
        outstanding <= replies_due.size();
        results_checked <= checked;
        runs_closed <= closed;
    end

endmodule

>>> sim/tb.sv
// Top of the random walk local time testbench: clock, reset, register settings and
// request stimulus with random idling on both channels, and the final verdict.
// Depends on rrwlt_pkg, the engine itself and rrwlt_checker.
`timescale 1ns / 100ps

module tb;
    import rrwlt_pkg::*;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    in_item_t              s_data      = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    out_item_t             m_data;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    int fail_count;
    int outstanding;
    int results_checked;
    int runs_closed;

    int n_steps    = 0;
    int n_reads    = 0;
    int n_settings = 1;
    int tx_left    = 0;
    bit tx_steady  = 1'b0;
    int rx_hold    = 0;
    int rx_span    = 0;
    bit rx_steady  = 1'b0;

    reset_random_walk_local_time DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    rrwlt_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .runs_closed     (runs_closed)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Mostly back to back, often a few cycles, now and then a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 90) return $urandom_range(1, 3);
        else return $urandom_range(10, 40);
    endfunction

    function automatic cfg_t make_knobs(logic [31:0] thr, logic [31:0] drift,
                                        logic [23:0] noise, logic [31:0] centre,
                                        logic [30:0] half, logic [23:0] steps,
                                        logic [15:0] per_bin);
        cfg_t c;
        c.reset_threshold = thr;
        c.drift_step = drift;
        c.noise_scale = noise;
        c.reset_position = centre;
        c.window_half = half;
        c.steps_per_run = steps;
        c.counts_per_bin = per_bin;
        return c;
    endfunction

    // Short runs and small divisors keep the bins low, so reads find counts.
    function automatic cfg_t random_knobs();
        cfg_t c;
        c = make_knobs($urandom >> $urandom_range(0, 8),
                       $signed($urandom) >>> $urandom_range(6, 31),
                       24'($urandom >> $urandom_range(8, 16)),
                       $urandom,
                       31'($urandom >> $urandom_range(4, 8)),
                       24'($urandom_range(1, 12)),
                       16'($urandom_range(1, 3)));
        if ($urandom_range(0, 5) == 0) c.steps_per_run = '0;
        if ($urandom_range(0, 5) == 0) c.counts_per_bin = '0;
        return c;
    endfunction

    function automatic in_item_t random_req();
        in_item_t r;
        r.reset_draw = $urandom;
        r.gauss_sample = 16'($urandom);
        r.read_bin = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
        r.req_type = ($urandom_range(0, 4) == 0) ? OP_READ : OP_STEP;
        return r;
    endfunction

    function automatic in_item_t step_req(logic [31:0] draw, logic [15:0] gauss);
        in_item_t r;
        r = random_req();
        r.req_type = OP_STEP;
        r.reset_draw = draw;
        r.gauss_sample = gauss;
        return r;
    endfunction

    function automatic in_item_t read_req(logic [11:0] bin);
        in_item_t r;
        r = random_req();
        r.req_type = OP_READ;
        r.read_bin = bin;
        return r;
    endfunction

    // Presents one request after a random gap and holds it until it is taken.
    task automatic send(in_item_t req);
        int gap;
        if (tx_left == 0) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            tx_left = $urandom_range(20, 60);
        end
        tx_left--;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (req.req_type == OP_READ) n_reads++;
        else n_steps++;
    endtask

    // Stops the request stream and waits until every result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
    endtask

    task automatic apply_knobs(cfg_t c);
        drain();
        write_reg(REG_RESET_THRESHOLD, c.reset_threshold);
        write_reg(REG_DRIFT_STEP, c.drift_step);
        write_reg(REG_NOISE_SCALE, 32'(c.noise_scale));
        write_reg(REG_RESET_POSITION, c.reset_position);
        write_reg(REG_WINDOW_HALF, 32'(c.window_half));
        write_reg(REG_STEPS_PER_RUN, 32'(c.steps_per_run));
        write_reg(REG_COUNTS_PER_BIN, 32'(c.counts_per_bin));
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // Result side stalls; some stretches run with the ready held high.
    always @(posedge aclk) begin
        if (rx_span == 0) begin
            rx_steady = ($urandom_range(0, 3) == 0);
            rx_span = $urandom_range(50, 250);
        end
        rx_span--;
        if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else begin
            m_ready <= 1'b1;
            if (!rx_steady) rx_hold = pick_gap();
        end
    end

    initial begin
        in_item_t r;
        int       i;
        int       p;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: empty bins at both ends, both sides of the reset
        // threshold and the largest Gaussian samples.
        send(read_req(12'd0));
        send(read_req(12'hFFF));
        send(step_req(32'd0, 16'h0123));
        send(step_req(32'hFFFF_FFFF, 16'h7FFF));
        send(step_req(32'hFFFF_FFFF, 16'h8000));
        send(step_req(CFG_RESET.reset_threshold, 16'h0000));
        send(step_req(CFG_RESET.reset_threshold - 32'd1, 16'hFFFF));

        // Walker pinned at the top rail, one step per run, widest window.
        apply_knobs(make_knobs(32'd0, 32'h8000_0000, 24'hFF_FFFF, 32'h7FFF_FFFF,
                               31'h7FFF_FFFF, 24'd1, 16'd1));
        send(step_req(32'hFFFF_FFFF, 16'h7FFF));
        send(step_req(32'h0000_0001, 16'h8000));
        send(read_req(12'd1));

        // Bottom rail, empty window, zero run length and zero divisor.
        apply_knobs(make_knobs(32'd0, 32'h7FFF_FFFF, 24'hFF_FFFF, 32'h8000_0000,
                               31'd0, 24'd0, 16'd0));
        send(step_req(32'h8000_0000, 16'h8000));
        send(step_req(32'hFFFF_FFFF, 16'h8000));
        send(read_req(12'd0));

        // Resets on every draw but the largest, no noise, largest divisor.
        apply_knobs(make_knobs(32'hFFFF_FFFF, 32'd0, 24'd0, 32'd0,
                               31'd1, 24'd3, 16'hFFFF));
        send(step_req(32'd0, 16'h7FFF));
        send(step_req(32'hFFFF_FFFF, 16'h8000));
        send(step_req(32'hFFFF_FFFF, 16'h5555));
        send(read_req(12'd0));

        // Longest run length: these steps never close a run.
        apply_knobs(make_knobs(32'd0, 32'd0, 24'hFF_FFFF, 32'd0,
                               31'd0, 24'hFF_FFFF, 16'd1));
        send(step_req(32'hFFFF_FFFF, 16'h2AAA));
        send(step_req(32'hFFFF_FFFF, 16'hD555));

        // One longer run that stays in the window, so its count is divided down to a bin.
        apply_knobs(make_knobs(32'hFFFF_FFFF, 32'd0, 24'hFF_FFFF, 32'd0,
                               31'h0010_0000, 24'd40, 16'd3));
        for (i = 0; i < 40; i++) begin
            r = random_req();
            r.req_type = OP_STEP;
            send(r);
        end
        send(read_req(12'd13));

        // Random settings, each with a stream of random steps and reads.
        for (p = 0; p < 6; p++) begin
            apply_knobs(random_knobs());
            for (i = 0; i < 90; i++) send(random_req());
        end

        drain();
        repeat (40) @(posedge aclk);
        $display("Sent %0d step and %0d read requests under %0d register settings.",
                 n_steps, n_reads, n_settings);
        $display("Checked %0d results, %0d of them closing a run.",
                 results_checked, runs_closed);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #60_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
